### rtl/float_fixed_point_quantizer_stats_assert.svh
// Assertion macros shared by the checker of the fake quantizer block.
// Each macro expands to one labeled concurrent assertion on i_clk and i_rst_n.
`ifndef FLOAT_FIXED_POINT_QUANTIZER_STATS_ASSERT_SVH
`define FLOAT_FIXED_POINT_QUANTIZER_STATS_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define FFQS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("quantizer assertion failed");

// Next-cycle implication, disabled while reset is held.
`define FFQS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("quantizer assertion failed");

`endif

### rtl/ffqs_pkg.sv
// Shared types and constants of the fake quantizer block.
// Used by the front, queue and back modules; depends on nothing.
package ffqs_pkg;

    // Register indexes of the configuration port
    localparam logic REG_INT_BITS  = 1'b0;
    localparam logic REG_FRAC_BITS = 1'b1;

    localparam logic [5:0] INT_BITS_RESET  = 6'd8;
    localparam logic [5:0] FRAC_BITS_RESET = 6'd8;

    // Midpoint between the two singles around 0.05, as 0x1999999 * 2^-29
    localparam logic [24:0] IMPR_RATIO = 25'h1999999;
    localparam int unsigned IMPR_SHIFT = 29;

    // One classified item between front and back
    typedef struct packed {
        logic [31:0] quant;    // quantized value, raw single bits
        logic        clip;     // saturated to a limit
        logic        chk;      // truncated, needs the precision check
        logic        last;     // final element of the tensor
        logic [23:0] dropped;  // significand bits removed by truncation
        logic [23:0] signif;   // full significand of the sample
    } t_entry;

endpackage

### rtl/ffqs_front.sv
// Front part: configuration registers, input acceptance and classification.
// Depends on ffqs_pkg; feeds the item queue.
module ffqs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [5:0]        i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [31:0]       i_sample,
    input  logic              i_last,
    input  logic              i_full,
    output logic              o_push,
    output ffqs_pkg::t_entry  o_entry
);
    import ffqs_pkg::*;

    logic [5:0]        r_int_bits;
    logic [5:0]        r_frac_bits;

    logic              s_sign;
    logic [7:0]        s_exp;
    logic [22:0]       s_man;
    logic              s_nan;
    logic              s_zero;
    logic [7:0]        s_exp_eff;
    logic [23:0]       s_signif;
    logic signed [9:0] s_cut;
    logic [6:0]        s_ksum;
    logic [4:0]        s_msh;
    logic [31:0]       s_rmax;
    logic [31:0]       s_rmin;
    logic [23:0]       s_low_mask;
    t_entry            s_entry;

    // Ordered compare of two non-NaN singles, a > b; both zeros compare equal
    function automatic logic f_gt(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ka;
        logic [31:0] kb;
        ka = a[31] ? ~a : (a | 32'h8000_0000);
        kb = b[31] ? ~b : (b | 32'h8000_0000);
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
            return 1'b0;
        end
        return ka > kb;
    endfunction

    // Hold the format registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_bits  <= INT_BITS_RESET;
            r_frac_bits <= FRAC_BITS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_INT_BITS:  r_int_bits  <= i_cfg_data;
                REG_FRAC_BITS: r_frac_bits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Range limits as singles
    always_comb begin
        s_ksum = {1'b0, r_int_bits} + {1'b0, r_frac_bits};
        s_msh  = 5'(s_ksum - 7'd2);
        s_rmin = {1'b1, 8'({2'b0, r_int_bits} + 8'd126), 23'd0};
        if (s_ksum == 7'd0) begin
            s_rmax = 32'hBF00_0000;
        end else if (s_ksum == 7'd1) begin
            s_rmax = 32'h0000_0000;
        end else if (s_ksum >= 7'd26) begin
            s_rmax = {1'b0, 8'({2'b0, r_int_bits} + 8'd126), 23'd0};
        end else begin
            s_rmax = {1'b0, 8'({2'b0, r_int_bits} + 8'd125), ~(23'h7F_FFFF >> s_msh)};
        end
    end

    // Classify the sample and truncate it to the grid
    always_comb begin
        s_sign     = i_sample[31];
        s_exp      = i_sample[30:23];
        s_man      = i_sample[22:0];
        s_nan      = (s_exp == 8'hFF) && (s_man != 23'd0);
        s_zero     = (i_sample[30:0] == 31'd0);
        s_exp_eff  = (s_exp == 8'd0) ? 8'd1 : s_exp;
        s_signif   = {(s_exp != 8'd0), s_man};
        s_cut      = 10'sd150 - $signed({4'b0, r_frac_bits}) - $signed({2'b0, s_exp_eff});
        s_low_mask = ~(24'hFF_FFFF << s_cut[4:0]);

        s_entry         = '0;
        s_entry.last    = i_last;
        s_entry.signif  = s_signif;
        if (s_nan) begin
            s_entry.quant = i_sample | 32'h0040_0000;
        end else if (f_gt(i_sample, s_rmax)) begin
            s_entry.quant = s_rmax;
            s_entry.clip  = 1'b1;
        end else if (f_gt(s_rmin, i_sample)) begin
            s_entry.quant = s_rmin;
            s_entry.clip  = 1'b1;
        end else if (s_zero) begin
            s_entry.quant = i_sample;
        end else begin
            s_entry.chk = 1'b1;
            if (s_cut <= 10'sd0) begin
                s_entry.quant = i_sample;
            end else if (s_cut >= 10'sd24) begin
                s_entry.quant   = {s_sign, 31'd0};
                s_entry.dropped = s_signif;
            end else begin
                s_entry.quant   = {s_sign, s_exp, s_man & ~s_low_mask[22:0]};
                s_entry.dropped = s_signif & s_low_mask;
            end
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign o_entry = s_entry;

endmodule

### rtl/ffqs_queue.sv
// Short item queue between the front and back parts.
// Depends on ffqs_pkg for the item type.
module ffqs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ffqs_pkg::t_entry  i_entry,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output ffqs_pkg::t_entry  o_entry
);
    import ffqs_pkg::*;

    localparam int Depth = 2;
    localparam int PtrW  = $clog2(Depth);

    t_entry            r_mem [Depth];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [PtrW:0]     r_count;

    // Store a pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= PtrW'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= PtrW'(r_rd_ptr + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PtrW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (PtrW+1)'(1);
            end
        end
    end

    assign o_full  = (r_count == (PtrW+1)'(Depth));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

endmodule

### rtl/ffqs_back.sv
// Back part: precision check, tallies and the output register.
// Depends on ffqs_pkg; pops items from the queue.
module ffqs_back #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ffqs_pkg::t_entry  i_entry,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_quantized,
    output logic              o_clipped,
    output logic              o_imprecise,
    output logic              o_last,
    output logic [31:0]       o_overflow_total,
    output logic [31:0]       o_imprecise_total,
    output logic [31:0]       o_element_total
);
    import ffqs_pkg::*;

    logic                   r_valid;
    logic [31:0]            r_quantized;
    logic                   r_clipped;
    logic                   r_imprecise;
    logic                   r_last;
    logic [31:0]            r_ovf_total;
    logic [31:0]            r_imp_total;
    logic [31:0]            r_elem_total;
    logic [COUNT_WIDTH-1:0] r_ovf_tally;
    logic [COUNT_WIDTH-1:0] r_imp_tally;
    logic [COUNT_WIDTH-1:0] r_elem_tally;
    logic [COUNT_WIDTH-1:0] n_ovf_tally;
    logic [COUNT_WIDTH-1:0] n_imp_tally;
    logic [COUNT_WIDTH-1:0] n_elem_tally;

    logic [48:0]            s_product;
    logic [52:0]            s_scaled_drop;
    logic                   s_impr;

    // Relative error check against the 0.05 threshold
    always_comb begin
        s_product     = IMPR_RATIO * i_entry.signif;
        s_scaled_drop = {i_entry.dropped, IMPR_SHIFT'(0)};
        s_impr        = i_entry.chk && (s_scaled_drop > {4'b0, s_product});
    end

    assign o_pop = i_valid && (!r_valid || i_ready);

    // Count this item
    always_comb begin
        n_elem_tally = r_elem_tally + COUNT_WIDTH'(1);
        n_ovf_tally  = r_ovf_tally + COUNT_WIDTH'(i_entry.clip);
        n_imp_tally  = r_imp_tally + COUNT_WIDTH'(s_impr);
    end

    // Hold tallies, clear them after the last item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_ovf_tally  <= '0;
            r_imp_tally  <= '0;
            r_elem_tally <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                if (i_entry.last) begin
                    r_ovf_tally  <= '0;
                    r_imp_tally  <= '0;
                    r_elem_tally <= '0;
                end else begin
                    r_ovf_tally  <= n_ovf_tally;
                    r_imp_tally  <= n_imp_tally;
                    r_elem_tally <= n_elem_tally;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_quantized <= i_entry.quant;
            r_clipped   <= i_entry.clip;
            r_imprecise <= s_impr;
            r_last      <= i_entry.last;
            if (i_entry.last) begin
                r_ovf_total  <= 32'(n_ovf_tally);
                r_imp_total  <= 32'(n_imp_tally);
                r_elem_total <= 32'(n_elem_tally);
            end else begin
                r_ovf_total  <= 32'd0;
                r_imp_total  <= 32'd0;
                r_elem_total <= 32'd0;
            end
        end
    end

    assign o_valid           = r_valid;
    assign o_quantized       = r_quantized;
    assign o_clipped         = r_clipped;
    assign o_imprecise       = r_imprecise;
    assign o_last            = r_last;
    assign o_overflow_total  = r_ovf_total;
    assign o_imprecise_total = r_imp_total;
    assign o_element_total   = r_elem_total;

endmodule

### rtl/float_fixed_point_quantizer_stats.sv
// An accepted item is written into the queue and then into the output register.
// Throughput: one item per cycle unless the result side stalls; the front classifies,
// a two-entry queue buffers, the back runs one 25x24 multiply and the tallies per item.
// Reset (synchronous, active low): int_bits and frac_bits return to 8,
// all tallies clear and the queue and output register empty.
// Depends on ffqs_pkg, ffqs_front, ffqs_queue and ffqs_back.
module float_fixed_point_quantizer_stats #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [5:0]   i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] sample
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // [31:0] quantized, [63:32] overflow_total,
                                         // [95:64] imprecise_total, [127:96] element_total
    output logic [1:0]   m_axis_tuser,   // [0] clipped, [1] imprecise
    output logic         m_axis_tlast
);
    import ffqs_pkg::*;

    logic   s_push;
    logic   s_full;
    logic   s_pop;
    logic   s_q_valid;
    t_entry s_front_entry;
    t_entry s_q_entry;

    ffqs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_sample    (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_full      (s_full),
        .o_push      (s_push),
        .o_entry     (s_front_entry)
    );

    ffqs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_entry (s_front_entry),
        .o_full  (s_full),
        .i_pop   (s_pop),
        .o_valid (s_q_valid),
        .o_entry (s_q_entry)
    );

    ffqs_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (s_q_valid),
        .i_entry           (s_q_entry),
        .o_pop             (s_pop),
        .o_valid           (m_axis_tvalid),
        .i_ready           (m_axis_tready),
        .o_quantized       (m_axis_tdata[31:0]),
        .o_clipped         (m_axis_tuser[0]),
        .o_imprecise       (m_axis_tuser[1]),
        .o_last            (m_axis_tlast),
        .o_overflow_total  (m_axis_tdata[63:32]),
        .o_imprecise_total (m_axis_tdata[95:64]),
        .o_element_total   (m_axis_tdata[127:96])
    );

endmodule

### rtl/ffqs_checker.sv
// Port-level checker of the fake quantizer block, bound to its top level.
// Depends on float_fixed_point_quantizer_stats_assert.svh.
`include "float_fixed_point_quantizer_stats_assert.svh"

module ffqs_port_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser,
    input logic         m_axis_tlast
);

    logic s_stall;
    logic s_mid;
    logic s_clip;
    logic s_nan_out;

    assign s_stall   = m_axis_tvalid && !m_axis_tready;
    assign s_mid     = m_axis_tvalid && !m_axis_tlast;
    assign s_clip    = m_axis_tvalid && m_axis_tuser[0];
    assign s_nan_out = (m_axis_tdata[30:23] == 8'hFF) && (m_axis_tdata[22:0] != 23'd0);

    // Stalled result holds
    `FFQS_ASSERT_NEXT(a_hold, s_stall, m_axis_tvalid && $stable(m_axis_tdata))

    // Totals only on the last result
    `FFQS_ASSERT_NOW(a_totals_zero, s_mid, m_axis_tdata[127:32] == 96'd0)

    // Saturated results are never counted imprecise
    `FFQS_ASSERT_NOW(a_flags_excl, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))

    // A saturated value is a limit, never NaN
    `FFQS_ASSERT_NOW(a_clip_not_nan, s_clip, !s_nan_out)

endmodule

bind float_fixed_point_quantizer_stats ffqs_port_checker u_ffqs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### tb/sv/ffqs_checker.sv
// Checker of the fake quantizer: watches the config, input and result channels,
// predicts each result, compares it field by field. Uses ffqs_pkg and the block's ports.
module ffqs_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [5:0]   i_cfg_data,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [31:0]  i_in_data,
    input  logic         i_in_last,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [127:0] i_out_data,
    input  logic [1:0]   i_out_user,
    input  logic         i_out_last,
    output int           o_errors,
    output int           o_pending
);
    import ffqs_pkg::*;

    typedef struct packed {
        logic [31:0] quant;
        logic        clip;
        logic        impr;
        logic        last;
        logic [31:0] ovf_tot;
        logic [31:0] impr_tot;
        logic [31:0] elem_tot;
    } t_quant_result;

    t_quant_result quant_results_q[$];
    logic [5:0]  int_bits_m, frac_bits_m;
    logic [31:0] ovf_cnt, impr_cnt, elem_cnt;
    int          errors;

    assign o_errors  = errors;
    assign o_pending = quant_results_q.size();

    // Single-precision bit pattern to its exact value; infinities map to huge values
    function automatic real float_value(logic [31:0] b);
        real r;
        logic [10:0] e11;
        if (b[30:23] == 8'hFF) begin
            r = 1.0e300;
        end else if (b[30:23] == 8'h00) begin
            r = real'(b[22:0]) * (2.0 ** (-149));
        end else begin
            e11 = {3'b000, b[30:23]} + 11'd896;
            r = $bitstoreal({1'b0, e11, b[22:0], 29'b0});
        end
        return b[31] ? -r : r;
    endfunction

    // Round a double to the nearest single, ties to even (normal range only)
    function automatic logic [31:0] round_to_single(real v);
        logic [63:0] d;
        logic [52:0] sig;
        logic [24:0] keep;
        logic [28:0] rem;
        int          e;
        d = $realtobits(v);
        if (d[62:0] == 63'd0) return {d[63], 31'd0};
        e = int'(d[62:52]) - 1023;
        sig = {1'b1, d[51:0]};
        keep = {1'b0, sig[52:29]};
        rem = sig[28:0];
        if (rem > 29'h10000000 || (rem == 29'h10000000 && keep[0])) keep = keep + 25'd1;
        if (keep[24]) begin
            keep = keep >> 1;
            e = e + 1;
        end
        return {d[63], 8'(e + 127), keep[22:0]};
    endfunction

    function automatic t_quant_result quantize_sample(logic [31:0] b, logic last);
        t_quant_result r;
        logic [31:0] lo_bits, hi_bits, mask;
        logic [23:0] sig, dropped;
        logic [63:0] lhs, rhs;
        int          m, n, e, k;
        real         x;
        m = int'(int_bits_m);
        n = int'(frac_bits_m);
        lo_bits = round_to_single(-(2.0 ** (m - 1)));
        hi_bits = round_to_single((2.0 ** (m - 1)) - (2.0 ** (-n)));
        x = float_value(b);
        r = '0;
        r.clip = 1'b0;
        r.impr = 1'b0;
        r.last = last;
        if (b[30:23] == 8'hFF && b[22:0] != 23'd0) begin
            // NaN: pass with the quiet bit set
            r.quant = b | 32'h00400000;
        end else if (x > float_value(hi_bits)) begin
            r.quant = hi_bits;
            r.clip = 1'b1;
        end else if (x < float_value(lo_bits)) begin
            r.quant = lo_bits;
            r.clip = 1'b1;
        end else if (b[30:0] == 31'd0) begin
            r.quant = b;
        end else begin
            // Truncate toward zero by clearing bits below 2^-n
            e = (b[30:23] == 8'h00) ? -149 : int'(b[30:23]) - 150;
            sig = {(b[30:23] != 8'h00), b[22:0]};
            if (e >= -n) begin
                r.quant = b;
                dropped = 24'd0;
            end else begin
                k = -n - e;
                if (k >= 24) begin
                    r.quant = {b[31], 31'd0};
                    dropped = sig;
                end else begin
                    mask = (32'd1 << k) - 32'd1;
                    r.quant = b & ~mask;
                    dropped = sig & mask[23:0];
                end
            end
            // Rounded single quotient exceeds 0.05 iff the exact ratio is past the midpoint
            lhs = {40'd0, dropped} << 29;
            rhs = 64'h1999999 * {40'd0, sig};
            r.impr = (lhs > rhs);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_quant_result got, want;
        if (!i_rst_n) begin
            int_bits_m  <= INT_BITS_RESET;
            frac_bits_m <= FRAC_BITS_RESET;
            ovf_cnt     <= '0;
            impr_cnt    <= '0;
            elem_cnt    <= '0;
            errors      <= 0;
            quant_results_q.delete();
        end else begin
            // Compare a delivered result with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                got.quant    = i_out_data[31:0];
                got.ovf_tot  = i_out_data[63:32];
                got.impr_tot = i_out_data[95:64];
                got.elem_tot = i_out_data[127:96];
                got.clip     = i_out_user[0];
                got.impr     = i_out_user[1];
                got.last     = i_out_last;
                if (quant_results_q.size() == 0) begin
                    $display("%0t: unexpected result quant=%h", $time, got.quant);
                    errors <= errors + 1;
                end else begin
                    want = quant_results_q.pop_front();
                    if (got != want) begin
                        $display("%0t: mismatch exp q=%h c=%b i=%b l=%b o=%0d p=%0d e=%0d",
                                 $time, want.quant, want.clip, want.impr, want.last,
                                 want.ovf_tot, want.impr_tot, want.elem_tot);
                        $display("%0t:          got q=%h c=%b i=%b l=%b o=%0d p=%0d e=%0d",
                                 $time, got.quant, got.clip, got.impr, got.last,
                                 got.ovf_tot, got.impr_tot, got.elem_tot);
                        errors <= errors + 1;
                    end
                end
            end
            // Predict the result of an accepted item and advance the tallies
            if (i_in_valid && i_in_ready) begin
                want = quantize_sample(i_in_data, i_in_last);
                if (i_in_last) begin
                    want.ovf_tot  = ovf_cnt + 32'(want.clip);
                    want.impr_tot = impr_cnt + 32'(want.impr);
                    want.elem_tot = elem_cnt + 32'd1;
                    ovf_cnt  <= '0;
                    impr_cnt <= '0;
                    elem_cnt <= '0;
                end else begin
                    want.ovf_tot  = '0;
                    want.impr_tot = '0;
                    want.elem_tot = '0;
                    ovf_cnt  <= ovf_cnt + 32'(want.clip);
                    impr_cnt <= impr_cnt + 32'(want.impr);
                    elem_cnt <= elem_cnt + 32'd1;
                end
                quant_results_q.push_back(want);
            end
            // Track register writes
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_INT_BITS) int_bits_m <= i_cfg_data;
                else frac_bits_m <= i_cfg_data;
            end
        end
    end
endmodule

### tb/sv/tb_float_fixed_point_quantizer_stats.sv
// Top of the fake quantizer testbench: drives config, samples and back-pressure,
// and gives the verdict. Depends on ffqs_pkg, the block and ffqs_checker.
module tb_float_fixed_point_quantizer_stats;
    import ffqs_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic         i_cfg_index;
    logic [5:0]   i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;   // [31:0] sample
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;   // [31:0] quantized, [63:32] overflow_total,
                                  // [95:64] imprecise_total, [127:96] element_total
    logic [1:0]   m_axis_tuser;   // [0] clipped, [1] imprecise
    logic         m_axis_tlast;
    int           errors;
    int           pending;
    bit           busy_phase;

    float_fixed_point_quantizer_stats i_dut (.*);

    ffqs_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_last(s_axis_tlast),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_user(m_axis_tuser), .i_out_last(m_axis_tlast),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

    // Mostly short gaps, a few long ones, none during busy stretches
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (busy_phase || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Random back-pressure on the result side
    always @(negedge i_clk) begin
        if (!i_rst_n || busy_phase) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 99) < 70);
    end

    task automatic write_reg(logic idx, logic [5:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_sample(logic [31:0] smp, logic last);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop input and let every prediction drain before returning
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);
    endtask

    // Random sample: mostly near the grid edges, some raw patterns and specials
    function automatic logic [31:0] pick_sample(int m, int n);
        int mode, lo, hi;
        logic [31:0] specials[8];
        specials = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
                     32'h7FC00001, 32'hFF800001, 32'h00000001, 32'h807FFFFF};
        mode = $urandom_range(0, 9);
        if (mode < 2) return $urandom;
        if (mode == 2) return specials[$urandom_range(0, 7)];
        lo = 127 - n - 26;
        hi = 127 + m + 1;
        if (lo < 0) lo = 0;
        if (hi > 254) hi = 254;
        return {1'($urandom), 8'($urandom_range(lo, hi)), 23'($urandom)};
    endfunction

    initial begin
        logic [31:0] directed[22];
        logic [5:0]  int_set[9], frac_set[9];
        int          count;
        directed = '{32'h00000000, 32'h80000000, 32'h7FC00000, 32'h7F800001,
                     32'hFFFFFFFF, 32'h7F800000, 32'hFF800000, 32'h42FF0000,
                     32'h42FF0100, 32'hC3000000, 32'hC3000001, 32'h3F800000,
                     32'h3F83D70A, 32'h3B000000, 32'hBA800000, 32'h00000001,
                     32'h80400000, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h3C23D70A,
                     32'h3F8CCCCD, 32'h43000000};
        int_set  = '{6'd8, 6'd1, 6'd32, 6'd1, 6'd32, 6'd0, 6'd63, 6'd20, 6'd5};
        frac_set = '{6'd8, 6'd0, 6'd32, 6'd32, 6'd0, 6'd63, 6'd63, 6'd5, 6'd0};
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_INT_BITS;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        busy_phase    = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(negedge i_clk);

        // Directed samples at the reset format
        foreach (directed[i]) send_sample(directed[i], (i == 10 || i == 21));
        drain();

        // Random phases over several formats, extremes included
        for (int p = 0; p < 10; p++) begin
            if (p < 9) begin
                write_reg(REG_INT_BITS, int_set[p]);
                write_reg(REG_FRAC_BITS, frac_set[p]);
            end else begin
                write_reg(REG_INT_BITS, 6'($urandom));
                write_reg(REG_FRAC_BITS, 6'($urandom));
            end
            busy_phase = (p == 3 || p == 7);
            count = (p == 9) ? 40 : 75;
            for (int k = 0; k < count; k++) begin
                send_sample(pick_sample(int'(int_set[p % 9]), int'(frac_set[p % 9])),
                            ($urandom_range(0, 19) == 0) || (k == count - 1));
            end
            busy_phase = 1'b0;
            drain();
        end

        repeat (10) @(negedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
